/* design/iapm_pkg.sv */
// Shared types, widths and constants of the inverse affine pixel map.
package iapm_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIM_W      = COORD_BITS + 1;
    localparam int COEF_W     = 24;
    localparam int SHIFT_W    = 13;
    localparam int OUT_W      = 16;
    localparam int CFG_W      = COEF_W;
    localparam int CFG_IDX_W  = 3;

    // translated coordinate: dst - centre - shift
    localparam int TR_W    = ((COORD_BITS + 1 > SHIFT_W) ? COORD_BITS + 1 : SHIFT_W) + 1;
    localparam int PROD_W  = COEF_W + TR_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int NMAG_W  = PROD_W;
    localparam int DPROD_W = 2 * COEF_W;
    localparam int DET_W   = DPROD_W + 1;
    // quotient bits kept; anything larger saturates unless the item is singular
    localparam int QUO_W   = OUT_W;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A,
        CFG_COEF_B,
        CFG_COEF_D,
        CFG_COEF_E,
        CFG_SHIFT_X,
        CFG_SHIFT_Y,
        CFG_WIDTH,
        CFG_HEIGHT
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0]  coef_a;
        logic signed [COEF_W-1:0]  coef_b;
        logic signed [COEF_W-1:0]  coef_d;
        logic signed [COEF_W-1:0]  coef_e;
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
        logic [DIM_W-1:0]          image_width;
        logic [DIM_W-1:0]          image_height;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        coef_a:       24'sd65536,
        coef_b:       24'sd0,
        coef_d:       24'sd0,
        coef_e:       24'sd65536,
        shift_x:      13'sd0,
        shift_y:      13'sd0,
        image_width:  13'd1024,
        image_height: 13'd1024
    };

    typedef struct packed {
        logic [COORD_BITS-1:0] dst_x;
        logic [COORD_BITS-1:0] dst_y;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] src_x;
        logic signed [OUT_W-1:0] src_y;
        logic                    singular;
        logic                    saturated;
    } t_out_item;

    // per-item status carried alongside the divider lanes
    typedef struct packed {
        logic sing;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
        logic rnz_x;
        logic rnz_y;
    } t_flags;

endpackage

/* design/inverse_affine_pixel_map.sv */
// Pipeline stages from input acceptance to o_valid: 4 front, 17 divider, 1 output stage.
// Throughput: one item per cycle; each stage holds its item under backpressure and bubbles
// close up, so input is still taken while a finished result waits on i_ready, if a stage is empty.
// Latency is set mostly by the 17-stage divider: one entry stage, then one quotient bit a stage.
// Reset (i_rst_n low at a clock edge) empties every stage and loads the identity transform,
// zero shift and a 1024 x 1024 image into the configuration registers.
module inverse_affine_pixel_map #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [iapm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [iapm_pkg::CFG_W-1:0]        i_cfg_data,
    // destination coordinate in
    input  logic                              i_valid,
    output logic                              o_ready,
    input  iapm_pkg::t_in_item                i_item,
    // source coordinate out
    output logic                              o_valid,
    input  logic                              i_ready,
    output iapm_pkg::t_out_item               o_item
);

    localparam int COEF_W  = iapm_pkg::COEF_W;
    localparam int SHIFT_W = iapm_pkg::SHIFT_W;
    localparam int DIM_W   = iapm_pkg::DIM_W;

    iapm_pkg::t_cfg r_cfg;

    // front end -> divider
    logic                                 w_p_vld, w_p_rdy;
    logic [iapm_pkg::NMAG_W-1:0]          w_p_nmag_x, w_p_nmag_y;
    logic [iapm_pkg::DPROD_W-1:0]         w_p_dmag;
    logic [iapm_pkg::COORD_BITS-1:0]      w_p_cx, w_p_cy;
    iapm_pkg::t_flags                     w_p_flags;

    // divider -> back end
    logic                                 w_d_vld, w_d_rdy;
    logic [iapm_pkg::QUO_W-1:0]           w_d_q_x, w_d_q_y;
    logic [iapm_pkg::COORD_BITS-1:0]      w_d_cx, w_d_cy;
    iapm_pkg::t_flags                     w_d_flags;

    // Configuration registers. The user must write them only with the pipeline empty;
    // the block does not enforce it. Every stage reads them directly as the item passes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= iapm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (iapm_pkg::t_cfg_idx'(i_cfg_idx))
                iapm_pkg::CFG_COEF_A:  r_cfg.coef_a       <= i_cfg_data[COEF_W-1:0];
                iapm_pkg::CFG_COEF_B:  r_cfg.coef_b       <= i_cfg_data[COEF_W-1:0];
                iapm_pkg::CFG_COEF_D:  r_cfg.coef_d       <= i_cfg_data[COEF_W-1:0];
                iapm_pkg::CFG_COEF_E:  r_cfg.coef_e       <= i_cfg_data[COEF_W-1:0];
                iapm_pkg::CFG_SHIFT_X: r_cfg.shift_x      <= i_cfg_data[SHIFT_W-1:0];
                iapm_pkg::CFG_SHIFT_Y: r_cfg.shift_y      <= i_cfg_data[SHIFT_W-1:0];
                iapm_pkg::CFG_WIDTH:   r_cfg.image_width  <= i_cfg_data[DIM_W-1:0];
                iapm_pkg::CFG_HEIGHT:  r_cfg.image_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Numerators nx = e*tx - b*ty, ny = a*ty - d*tx with t = dst - centre - shift,
    // determinant a*e - b*d, then sign/magnitude split.
    iapm_prod u_prod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_vld    (i_valid),
        .o_rdy    (o_ready),
        .i_item   (i_item),
        .o_vld    (w_p_vld),
        .i_rdy    (w_p_rdy),
        .o_nmag_x (w_p_nmag_x),
        .o_nmag_y (w_p_nmag_y),
        .o_dmag   (w_p_dmag),
        .o_ctr_x  (w_p_cx),
        .o_ctr_y  (w_p_cy),
        .o_flags  (w_p_flags)
    );

    // |n| * 2^FRAC_BITS / |det|: only 16 quotient bits matter, larger
    // quotients are flagged as overflow and clamp later.
    iapm_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_p_vld),
        .o_rdy    (w_p_rdy),
        .i_nmag_x (w_p_nmag_x),
        .i_nmag_y (w_p_nmag_y),
        .i_dmag   (w_p_dmag),
        .i_ctr_x  (w_p_cx),
        .i_ctr_y  (w_p_cy),
        .i_flags  (w_p_flags),
        .o_vld    (w_d_vld),
        .i_rdy    (w_d_rdy),
        .o_q_x    (w_d_q_x),
        .o_q_y    (w_d_q_y),
        .o_ctr_x  (w_d_cx),
        .o_ctr_y  (w_d_cy),
        .o_flags  (w_d_flags)
    );

    // Adds the centre back, truncates the whole sum toward zero and clamps.
    iapm_fix u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_d_vld),
        .o_rdy   (w_d_rdy),
        .i_q_x   (w_d_q_x),
        .i_q_y   (w_d_q_y),
        .i_ctr_x (w_d_cx),
        .i_ctr_y (w_d_cy),
        .i_flags (w_d_flags),
        .o_vld   (o_valid),
        .i_rdy   (i_ready),
        .o_item  (o_item)
    );

endmodule

/* design/iapm_prod.sv */
// Front end: translation, products, numerators, determinant and magnitudes.
module iapm_prod (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iapm_pkg::t_cfg                    i_cfg,
    input  logic                              i_vld,
    output logic                              o_rdy,
    input  iapm_pkg::t_in_item                i_item,
    output logic                              o_vld,
    input  logic                              i_rdy,
    output logic [iapm_pkg::NMAG_W-1:0]       o_nmag_x,
    output logic [iapm_pkg::NMAG_W-1:0]       o_nmag_y,
    output logic [iapm_pkg::DPROD_W-1:0]      o_dmag,
    output logic [iapm_pkg::COORD_BITS-1:0]   o_ctr_x,
    output logic [iapm_pkg::COORD_BITS-1:0]   o_ctr_y,
    output iapm_pkg::t_flags                  o_flags
);

    localparam int TR_W    = iapm_pkg::TR_W;
    localparam int PROD_W  = iapm_pkg::PROD_W;
    localparam int NUM_W   = iapm_pkg::NUM_W;
    localparam int NMAG_W  = iapm_pkg::NMAG_W;
    localparam int DPROD_W = iapm_pkg::DPROD_W;
    localparam int DET_W   = iapm_pkg::DET_W;
    localparam int CB      = iapm_pkg::COORD_BITS;
    localparam int DIM_W   = iapm_pkg::DIM_W;

    logic [3:0] r_vld;
    logic [4:0] w_adv;

    // stage 1
    logic [CB-1:0]            w_cx, w_cy;
    logic signed [TR_W-1:0]   n_tx, n_ty;
    logic signed [TR_W-1:0]   r1_tx, r1_ty;
    logic [CB-1:0]            r1_cx, r1_cy;
    // stage 2
    logic signed [PROD_W-1:0]  r2_pex, r2_pby, r2_pay, r2_pdx;
    logic signed [DPROD_W-1:0] r2_pae, r2_pbd;
    logic [CB-1:0]             r2_cx, r2_cy;
    // stage 3
    logic signed [NUM_W-1:0]  r3_nx, r3_ny;
    logic signed [DET_W-1:0]  r3_det;
    logic [CB-1:0]            r3_cx, r3_cy;
    // stage 4
    logic [NMAG_W-1:0]        n_nmag_x, n_nmag_y;
    logic [DPROD_W-1:0]       n_dmag;
    iapm_pkg::t_flags         n_flags;
    logic [NMAG_W-1:0]        r4_nmag_x, r4_nmag_y;
    logic [DPROD_W-1:0]       r4_dmag;
    logic [CB-1:0]            r4_cx, r4_cy;
    iapm_pkg::t_flags         r4_flags;

    assign w_adv[4] = i_rdy;
    assign w_adv[3] = !r_vld[3] || w_adv[4];
    assign w_adv[2] = !r_vld[2] || w_adv[3];
    assign w_adv[1] = !r_vld[1] || w_adv[2];
    assign w_adv[0] = !r_vld[0] || w_adv[1];
    assign o_rdy    = w_adv[0];
    assign o_vld    = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_vld;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
            if (w_adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    // centre is the dimension halved, rounded down
    always_comb begin
        w_cx = i_cfg.image_width[DIM_W-1:1];
        w_cy = i_cfg.image_height[DIM_W-1:1];
        n_tx = TR_W'($signed({1'b0, i_item.dst_x})) - TR_W'($signed({1'b0, w_cx}))
             - TR_W'(i_cfg.shift_x);
        n_ty = TR_W'($signed({1'b0, i_item.dst_y})) - TR_W'($signed({1'b0, w_cy}))
             - TR_W'(i_cfg.shift_y);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0] && i_vld) begin
            r1_tx <= n_tx;
            r1_ty <= n_ty;
            r1_cx <= w_cx;
            r1_cy <= w_cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1] && r_vld[0]) begin
            r2_pex <= PROD_W'(i_cfg.coef_e) * PROD_W'(r1_tx);
            r2_pby <= PROD_W'(i_cfg.coef_b) * PROD_W'(r1_ty);
            r2_pay <= PROD_W'(i_cfg.coef_a) * PROD_W'(r1_ty);
            r2_pdx <= PROD_W'(i_cfg.coef_d) * PROD_W'(r1_tx);
            r2_pae <= DPROD_W'(i_cfg.coef_a) * DPROD_W'(i_cfg.coef_e);
            r2_pbd <= DPROD_W'(i_cfg.coef_b) * DPROD_W'(i_cfg.coef_d);
            r2_cx  <= r1_cx;
            r2_cy  <= r1_cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2] && r_vld[1]) begin
            r3_nx  <= NUM_W'(r2_pex) - NUM_W'(r2_pby);
            r3_ny  <= NUM_W'(r2_pay) - NUM_W'(r2_pdx);
            r3_det <= DET_W'(r2_pae) - DET_W'(r2_pbd);
            r3_cx  <= r2_cx;
            r3_cy  <= r2_cy;
        end
    end

    // sign and magnitude split; a zero numerator counts as positive
    always_comb begin
        n_nmag_x = r3_nx[NUM_W-1] ? NMAG_W'(-r3_nx) : NMAG_W'(r3_nx);
        n_nmag_y = r3_ny[NUM_W-1] ? NMAG_W'(-r3_ny) : NMAG_W'(r3_ny);
        n_dmag   = r3_det[DET_W-1] ? DPROD_W'(-r3_det) : DPROD_W'(r3_det);
        n_flags       = '0;
        n_flags.sing  = (r3_det == '0);
        n_flags.neg_x = (r3_nx[NUM_W-1] ^ r3_det[DET_W-1]) && (r3_nx != '0);
        n_flags.neg_y = (r3_ny[NUM_W-1] ^ r3_det[DET_W-1]) && (r3_ny != '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3] && r_vld[2]) begin
            r4_nmag_x <= n_nmag_x;
            r4_nmag_y <= n_nmag_y;
            r4_dmag   <= n_dmag;
            r4_cx     <= r3_cx;
            r4_cy     <= r3_cy;
            r4_flags  <= n_flags;
        end
    end

    assign o_nmag_x = r4_nmag_x;
    assign o_nmag_y = r4_nmag_y;
    assign o_dmag   = r4_dmag;
    assign o_ctr_x  = r4_cx;
    assign o_ctr_y  = r4_cy;
    assign o_flags  = r4_flags;

endmodule

/* design/iapm_div.sv */
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
module iapm_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    output logic                              o_rdy,
    input  logic [iapm_pkg::NMAG_W-1:0]       i_nmag_x,
    input  logic [iapm_pkg::NMAG_W-1:0]       i_nmag_y,
    input  logic [iapm_pkg::DPROD_W-1:0]      i_dmag,
    input  logic [iapm_pkg::COORD_BITS-1:0]   i_ctr_x,
    input  logic [iapm_pkg::COORD_BITS-1:0]   i_ctr_y,
    input  iapm_pkg::t_flags                  i_flags,
    output logic                              o_vld,
    input  logic                              i_rdy,
    output logic [iapm_pkg::QUO_W-1:0]        o_q_x,
    output logic [iapm_pkg::QUO_W-1:0]        o_q_y,
    output logic [iapm_pkg::COORD_BITS-1:0]   o_ctr_x,
    output logic [iapm_pkg::COORD_BITS-1:0]   o_ctr_y,
    output iapm_pkg::t_flags                  o_flags
);

    localparam int QUO_W   = iapm_pkg::QUO_W;
    localparam int DPROD_W = iapm_pkg::DPROD_W;
    localparam int CB      = iapm_pkg::COORD_BITS;
    localparam int DIVD_W  = iapm_pkg::NMAG_W + FRAC_BITS;
    localparam int DSH_W   = DPROD_W + QUO_W;
    localparam int REM_W   = (DIVD_W > DSH_W) ? DIVD_W : DSH_W;

    logic               r_vld   [0:QUO_W];
    logic               w_adv   [0:QUO_W+1];
    logic [REM_W-1:0]   r_rem_x [0:QUO_W];
    logic [REM_W-1:0]   r_rem_y [0:QUO_W];
    logic [QUO_W-1:0]   r_q_x   [0:QUO_W];
    logic [QUO_W-1:0]   r_q_y   [0:QUO_W];
    logic [DPROD_W-1:0] r_dmag  [0:QUO_W-1];
    logic [CB-1:0]      r_cx    [0:QUO_W];
    logic [CB-1:0]      r_cy    [0:QUO_W];
    iapm_pkg::t_flags   r_flags [0:QUO_W];

    logic [REM_W-1:0]   n_rem_x, n_rem_y, w_dlim;
    iapm_pkg::t_flags   n_flags;

    assign w_adv[QUO_W+1] = i_rdy;
    assign w_adv[0]       = !r_vld[0] || w_adv[1];
    assign o_rdy          = w_adv[0];

    // entry stage: scale the dividend and flag quotients too big to keep
    always_comb begin
        n_rem_x = REM_W'(i_nmag_x) << FRAC_BITS;
        n_rem_y = REM_W'(i_nmag_y) << FRAC_BITS;
        w_dlim  = REM_W'(i_dmag) << QUO_W;
        n_flags       = i_flags;
        n_flags.ovf_x = (n_rem_x >= w_dlim);
        n_flags.ovf_y = (n_rem_y >= w_dlim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv[0]) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0] && i_vld) begin
            r_rem_x[0] <= n_rem_x;
            r_rem_y[0] <= n_rem_y;
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_dmag[0]  <= i_dmag;
            r_cx[0]    <= i_ctr_x;
            r_cy[0]    <= i_ctr_y;
            r_flags[0] <= n_flags;
        end
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_step
        logic [REM_W-1:0] w_ds;
        logic             w_ge_x, w_ge_y;

        assign w_ds     = REM_W'(r_dmag[s-1]) << (QUO_W - s);
        assign w_ge_x   = (r_rem_x[s-1] >= w_ds);
        assign w_ge_y   = (r_rem_y[s-1] >= w_ds);
        assign w_adv[s] = !r_vld[s] || w_adv[s+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_adv[s]) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[s] && r_vld[s-1]) begin
                r_rem_x[s] <= w_ge_x ? r_rem_x[s-1] - w_ds : r_rem_x[s-1];
                r_rem_y[s] <= w_ge_y ? r_rem_y[s-1] - w_ds : r_rem_y[s-1];
                r_q_x[s]   <= {r_q_x[s-1][QUO_W-2:0], w_ge_x};
                r_q_y[s]   <= {r_q_y[s-1][QUO_W-2:0], w_ge_y};
                r_cx[s]    <= r_cx[s-1];
                r_cy[s]    <= r_cy[s-1];
                r_flags[s] <= r_flags[s-1];
            end
        end

        if (s < QUO_W) begin : g_dmag
            always_ff @(posedge i_clk) begin
                if (w_adv[s] && r_vld[s-1]) begin
                    r_dmag[s] <= r_dmag[s-1];
                end
            end
        end
    end

    assign o_vld   = r_vld[QUO_W];
    assign o_q_x   = r_q_x[QUO_W];
    assign o_q_y   = r_q_y[QUO_W];
    assign o_ctr_x = r_cx[QUO_W];
    assign o_ctr_y = r_cy[QUO_W];

    always_comb begin
        o_flags       = r_flags[QUO_W];
        o_flags.rnz_x = |r_rem_x[QUO_W];
        o_flags.rnz_y = |r_rem_y[QUO_W];
    end

endmodule

/* design/iapm_fix.sv */
// Back end: sign, centre offset, truncation toward zero, clamping, singular handling and output register.
module iapm_fix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    output logic                              o_rdy,
    input  logic [iapm_pkg::QUO_W-1:0]        i_q_x,
    input  logic [iapm_pkg::QUO_W-1:0]        i_q_y,
    input  logic [iapm_pkg::COORD_BITS-1:0]   i_ctr_x,
    input  logic [iapm_pkg::COORD_BITS-1:0]   i_ctr_y,
    input  iapm_pkg::t_flags                  i_flags,
    output logic                              o_vld,
    input  logic                              i_rdy,
    output iapm_pkg::t_out_item               o_item
);

    localparam int QUO_W = iapm_pkg::QUO_W;
    localparam int OUT_W = iapm_pkg::OUT_W;
    localparam int CB    = iapm_pkg::COORD_BITS;
    localparam int SUM_W = QUO_W + 2;

    logic                r_vld;
    iapm_pkg::t_out_item r_item;
    iapm_pkg::t_out_item n_item;
    logic [OUT_W:0]      w_ax, w_ay;

    // returns {saturated, coordinate}
    function automatic logic [OUT_W:0] f_axis(
        input logic [QUO_W-1:0] q,
        input logic [CB-1:0]    ctr,
        input logic             neg,
        input logic             ovf,
        input logic             rnz
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [OUT_W-1:0] val;
        logic                    sat;
        if (neg) begin
            sum = SUM_W'(ctr) - SUM_W'(q);
            // fraction below a positive base: truncation drops one more
            if (rnz && (sum > SUM_W'(0))) begin
                sum = sum - SUM_W'(1);
            end
        end else begin
            sum = SUM_W'(ctr) + SUM_W'(q);
        end
        sat = 1'b1;
        if (ovf) begin
            val = neg ? iapm_pkg::OUT_MIN : iapm_pkg::OUT_MAX;
        end else if (sum > SUM_W'(iapm_pkg::OUT_MAX)) begin
            val = iapm_pkg::OUT_MAX;
        end else if (sum < SUM_W'(iapm_pkg::OUT_MIN)) begin
            val = iapm_pkg::OUT_MIN;
        end else begin
            val = OUT_W'(sum);
            sat = 1'b0;
        end
        return {sat, val};
    endfunction

    always_comb begin
        w_ax = f_axis(i_q_x, i_ctr_x, i_flags.neg_x, i_flags.ovf_x, i_flags.rnz_x);
        w_ay = f_axis(i_q_y, i_ctr_y, i_flags.neg_y, i_flags.ovf_y, i_flags.rnz_y);
        if (i_flags.sing) begin
            n_item.src_x     = '0;
            n_item.src_y     = '0;
            n_item.singular  = 1'b1;
            n_item.saturated = 1'b0;
        end else begin
            n_item.src_x     = w_ax[OUT_W-1:0];
            n_item.src_y     = w_ay[OUT_W-1:0];
            n_item.singular  = 1'b0;
            n_item.saturated = w_ax[OUT_W] | w_ay[OUT_W];
        end
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule
